// ===== src/uuencode_line_encoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// uuencode line encoder: assertion macros
// Shared property wrappers, clocked on clock and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef UUENCODE_LINE_ENCODER_TOP_DEFINES_SVH
`define UUENCODE_LINE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define UULE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UULE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/uule_pkg.sv =====
// ----------------------------------------------------------------------------
// uuencode line encoder package
// Shared widths, character codes and sequencer types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uule_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned RES_W  = 6;

   localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

   // index of the last request result that may be delivered
   localparam logic [RES_W-1:0] LAST_RESULT = 6'd63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_GRP,
      ST_NL,
      ST_TSP,
      ST_TNL
   } state_type;

   typedef enum logic [1:0] {
      PH_HI,
      PH_MID,
      PH_LOW,
      PH_TAIL
   } phase_type;

   // map a six-bit value onto its printable character
   function automatic logic [BYTE_W-1:0] enc6(input logic [5:0] value);
      enc6 = {2'b00, value} + SPACE_CHAR;
   endfunction

endpackage

// ===== src/uule_if.sv =====
// ----------------------------------------------------------------------------
// uuencode line encoder channels
// Valid/ready interfaces for the byte request and the character result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface uule_req_if;
   logic                          valid;
   logic                          ready;
   logic [uule_pkg::BYTE_W-1:0]   data_byte;
   logic                          byte_present;
   logic                          end_of_data;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input end_of_data, output ready);
endinterface

interface uule_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [uule_pkg::BYTE_W-1:0]   out_char;
   logic                          last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== src/uuencode_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// uuencode line encoder, top level
// After a request is accepted, the sequencer leaves idle and its first character moves into
// the output register once that register is free or being drained.
// A request that emits nothing returns straight to idle; one that sends a line steps
// through accept, length, groups and newline, then the terminator if the stream ends;
// one character per cycle while the output is not stalled.
// Reset: synchronous; clears the sequencer, byte count and output valid; line store not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uuencode_line_encoder_top_defines.svh"

module uuencode_line_encoder_top #(
   parameter int unsigned LINE_BYTES = 45
) (
   input  logic          clock,
   input  logic          reset,
   uule_req_if.sink      req_bus,
   uule_rsp_if.source    rsp_bus
);

   localparam int unsigned ADDR_W = $clog2(LINE_BYTES);
   localparam int unsigned CNT_W  = $clog2(LINE_BYTES + 1);
   localparam int unsigned IDX_W  = $clog2(LINE_BYTES + 3);
   localparam int unsigned BW     = uule_pkg::BYTE_W;

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   uule_pkg::state_type    state_ff, state_in;
   uule_pkg::phase_type    phase_ff, phase_in;
   logic [CNT_W-1:0]       count_ff, count_in;     // bytes held in the line store
   logic [CNT_W-1:0]       len_ff, len_in;         // length of the line being sent
   logic                   term_ff, term_in;       // terminator follows the line
   logic [IDX_W-1:0]       idx_ff, idx_in;         // byte index of the read port
   logic [BW-1:0]          prev_ff, prev_in;       // previous byte of the group
   logic [uule_pkg::RES_W-1:0] res_ff, res_in;     // results sent for this request

   logic [BW-1:0]          rd_data_ff;             // registered read of line_store[idx_ff]
   logic [ADDR_W-1:0]      rd_addr;

   logic                   out_valid_ff, out_valid_in;
   logic [BW-1:0]          out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;

   // line store: one write port for incoming bytes, one registered read port
   logic [BW-1:0]          line_store [LINE_BYTES];

   // ---------------------------------------------------------------------------
   // Request side: take a request only while the sequencer is idle
   // ---------------------------------------------------------------------------
   logic                   req_take;
   logic [CNT_W-1:0]       cnt_plus;
   logic                   line_full;
   logic                   do_line;

   assign req_bus.ready = (state_ff == uule_pkg::ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;

   // store the byte first, then decide whether a line goes out
   assign cnt_plus  = count_ff + CNT_W'(req_bus.byte_present);
   assign line_full = req_bus.byte_present && (cnt_plus == CNT_W'(LINE_BYTES));
   assign do_line   = line_full || (req_bus.end_of_data && (cnt_plus != '0));

   // ---------------------------------------------------------------------------
   // Output side: a character moves into the output register when it is free
   // or being drained in this cycle
   // ---------------------------------------------------------------------------
   logic                   advance;
   logic                   emit;

   assign advance = !out_valid_ff || rsp_bus.ready;
   assign emit    = (state_ff != uule_pkg::ST_IDLE) && advance;

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.out_char    = out_char_ff;
   assign rsp_bus.last_of_run = out_last_ff;

   // ---------------------------------------------------------------------------
   // Shared encode unit: pick six bits out of the current byte pair and offset
   // them into the printable range. Bytes past the line length read as zero,
   // which fills the missing bytes of a short final group.
   // ---------------------------------------------------------------------------
   logic [BW-1:0]          cur_byte;
   logic [5:0]             six;
   logic [BW-1:0]          enc_char;

   assign cur_byte = (idx_ff < IDX_W'(len_ff)) ? rd_data_ff : '0;

   always_comb begin
      six = '0;
      case (phase_ff)
         uule_pkg::PH_HI:   six = cur_byte[7:2];
         uule_pkg::PH_MID:  six = {prev_ff[1:0], cur_byte[7:4]};
         uule_pkg::PH_LOW:  six = {prev_ff[3:0], cur_byte[7:6]};
         uule_pkg::PH_TAIL: six = prev_ff[5:0];
         default:           six = '0;
      endcase
      if (state_ff == uule_pkg::ST_LEN) begin
         six = 6'(len_ff);
      end
   end

   assign enc_char = uule_pkg::enc6(six);

   // ---------------------------------------------------------------------------
   // Sequencer: length character, four characters per group, newline, and the
   // terminator line at end of data. The read port runs one index ahead so the
   // registered read data always belongs to idx_ff.
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      term_in      = term_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      // drop the valid once the held character is taken
      out_valid_in = out_valid_ff && !rsp_bus.ready;

      case (state_ff)
         uule_pkg::ST_IDLE: begin
            if (req_take) begin
               // flush or end of stream empties the store
               count_in = (do_line || req_bus.end_of_data) ? '0 : cnt_plus;
               len_in   = cnt_plus;
               term_in  = req_bus.end_of_data;
               idx_in   = '0;
               phase_in = uule_pkg::PH_HI;
               res_in   = '0;
               if (do_line) begin
                  state_in = uule_pkg::ST_LEN;
               end else if (req_bus.end_of_data) begin
                  state_in = uule_pkg::ST_TSP;
               end
            end
         end
         uule_pkg::ST_LEN: begin
            if (emit) begin
               state_in = uule_pkg::ST_GRP;
               phase_in = uule_pkg::PH_HI;
            end
         end
         uule_pkg::ST_GRP: begin
            if (emit) begin
               case (phase_ff)
                  uule_pkg::PH_HI: begin
                     prev_in  = cur_byte;
                     idx_in   = idx_ff + IDX_W'(1);
                     phase_in = uule_pkg::PH_MID;
                  end
                  uule_pkg::PH_MID: begin
                     prev_in  = cur_byte;
                     idx_in   = idx_ff + IDX_W'(1);
                     phase_in = uule_pkg::PH_LOW;
                  end
                  uule_pkg::PH_LOW: begin
                     prev_in  = cur_byte;
                     idx_in   = idx_ff + IDX_W'(1);
                     phase_in = uule_pkg::PH_TAIL;
                  end
                  uule_pkg::PH_TAIL: begin
                     // idx_ff already points at the next group
                     phase_in = uule_pkg::PH_HI;
                     if (idx_ff >= IDX_W'(len_ff)) begin
                        state_in = uule_pkg::ST_NL;
                     end
                  end
                  default: phase_in = uule_pkg::PH_HI;
               endcase
            end
         end
         uule_pkg::ST_NL: begin
            if (emit) begin
               state_in = term_ff ? uule_pkg::ST_TSP : uule_pkg::ST_IDLE;
            end
         end
         uule_pkg::ST_TSP: begin
            if (emit) begin
               state_in = uule_pkg::ST_TNL;
            end
         end
         uule_pkg::ST_TNL: begin
            if (emit) begin
               state_in = uule_pkg::ST_IDLE;
            end
         end
         default: state_in = uule_pkg::ST_IDLE;
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
         res_in       = res_ff + uule_pkg::RES_W'(1);
         case (state_ff)
            uule_pkg::ST_NL:  out_char_in = uule_pkg::NEWLINE_CHAR;
            uule_pkg::ST_TSP: out_char_in = uule_pkg::SPACE_CHAR;
            uule_pkg::ST_TNL: out_char_in = uule_pkg::NEWLINE_CHAR;
            default:          out_char_in = enc_char;
         endcase
         out_last_in = (state_ff == uule_pkg::ST_TNL) ||
                       ((state_ff == uule_pkg::ST_NL) && !term_ff) ||
                       (res_ff == uule_pkg::LAST_RESULT);
         // result cap reached: drop whatever this request still had to send
         if (res_ff == uule_pkg::LAST_RESULT) begin
            state_in = uule_pkg::ST_IDLE;
         end
      end
   end

   // out-of-range indices only occur past the line length, where data is masked
   assign rd_addr = (idx_in < IDX_W'(LINE_BYTES)) ? idx_in[ADDR_W-1:0] : '0;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uule_pkg::ST_IDLE;
         phase_ff     <= uule_pkg::PH_HI;
         count_ff     <= '0;
         term_ff      <= 1'b0;
         idx_ff       <= '0;
         res_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         term_ff      <= term_in;
         idx_ff       <= idx_in;
         res_ff       <= res_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      prev_ff     <= prev_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // line store write and registered read
   always_ff @(posedge clock) begin
      if (req_take && req_bus.byte_present) begin
         line_store[count_ff[ADDR_W-1:0]] <= req_bus.data_byte;
      end
      rd_data_ff <= line_store[rd_addr];
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   // short terms for the checks below
   logic [IDX_W-1:0]       idx_limit;
   logic                   take_end;
   logic                   take_idle;
   logic                   busy;

   assign idx_limit = IDX_W'(len_ff) + IDX_W'(2);
   assign take_end  = req_take && req_bus.end_of_data;
   assign take_idle = req_take && !req_bus.byte_present && !req_bus.end_of_data;
   assign busy      = (state_ff != uule_pkg::ST_IDLE);

   `UULE_ASSERT_NOW(a_count_below_line, 1'b1, count_ff < CNT_W'(LINE_BYTES), "store overflow")
   `UULE_ASSERT_NOW(a_idx_bound, state_ff == uule_pkg::ST_GRP, idx_ff <= idx_limit, "bad index")
   `UULE_ASSERT_NEXT(a_eod_flushes, take_end, (count_ff == '0) && busy, "no flush at end")
   `UULE_ASSERT_NEXT(a_idle_request, take_idle, $stable(count_ff) && !busy, "idle moved")

endmodule

// ===== dv/tb_uuencode_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// uuencode line encoder testbench
// Sends byte streams into the encoder and checks every output character, and
// its end-of-request flag, against an in-bench line encoder or a typed row.
// A short table of directed requests comes first; random streams follow in four
// flow-control phases: free running, sender gaps, receiver stalls, and both.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uuencode_line_encoder_top;

   localparam int LINE_LEN       = 45;   // bytes per full encoded line
   localparam int RANDOM_ITEMS   = 320;  // byte and end requests in the random part
   localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 20;   // settle time once nothing is pending
   localparam int REPORT_LIMIT   = 10;   // mismatches printed in full
   localparam int N_DIRECTED     = 21;

   typedef struct packed {
      logic [uule_pkg::BYTE_W-1:0] out_char;
      logic                        last_of_run;
   } uu_char_type;

   // one directed request; where typed is set, typed_chars is the whole
   // expected response and the last character carries last_of_run
   typedef struct {
      logic [uule_pkg::BYTE_W-1:0] data_byte;
      logic                        byte_present;
      logic                        end_of_data;
      bit                          typed;
      string                       typed_chars;
   } stim_row_type;

   logic clock;
   logic reset;

   uule_req_if req_bus ();
   uule_rsp_if rsp_bus ();

   uuencode_line_encoder_top #(
      .LINE_BYTES (LINE_LEN)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Directed table. Rows with a typed response can be read off at a glance:
   // an empty store gives only the terminator, an idle request gives nothing,
   // a single zero byte closing a stream gives length '!', four spaces, a newline and the terminator.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, " \n"},          // bare end straight after reset
      '{8'h5A, 1'b0, 1'b0, 1'b1, ""},             // idle request: byte ignored
      '{8'h00, 1'b1, 1'b1, 1'b1, "!    \n \n"},   // lone zero byte closing a stream
      '{8'hFF, 1'b1, 1'b1, 1'b0, ""},             // lone all-ones byte
      '{8'hFF, 1'b1, 1'b0, 1'b0, ""},             // two bytes: last group short by one
      '{8'hFF, 1'b1, 1'b1, 1'b0, ""},
      '{8'h01, 1'b1, 1'b0, 1'b0, ""},             // exact group closed by bare end
      '{8'h80, 1'b1, 1'b0, 1'b0, ""},
      '{8'h7F, 1'b1, 1'b0, 1'b0, ""},
      '{8'h00, 1'b0, 1'b1, 1'b0, ""},
      '{8'hA5, 1'b1, 1'b0, 1'b0, ""},             // five bytes, idle request inside
      '{8'h5A, 1'b1, 1'b0, 1'b0, ""},
      '{8'hC3, 1'b1, 1'b0, 1'b0, ""},
      '{8'h3C, 1'b1, 1'b0, 1'b0, ""},
      '{8'hFF, 1'b0, 1'b0, 1'b1, ""},
      '{8'h96, 1'b1, 1'b1, 1'b0, ""},
      '{8'h00, 1'b0, 1'b1, 1'b1, " \n"},          // end on an empty store
      '{8'hAA, 1'b1, 1'b0, 1'b0, ""},             // two bytes, idle, bare end
      '{8'h55, 1'b1, 1'b0, 1'b0, ""},
      '{8'h00, 1'b0, 1'b0, 1'b1, ""},
      '{8'h00, 1'b0, 1'b1, 1'b0, ""}
   };

   // in-bench copy of the encoder state
   logic [uule_pkg::BYTE_W-1:0] held_bytes [LINE_LEN];
   int                          held_count;

   uu_char_type pending_chars [$];   // characters still owed by the DUT, oldest first
   uu_char_type step_chars [$];      // response of the request just accepted

   int send_idle_pct;
   int rx_stall_pct;
   int error_count;
   int requests_sent;
   int chars_checked;
   int streams_sent;
   int full_lines;
   int idle_cycles;

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Line encoder model
   // ------------------------------------------------------------------------
   function automatic logic [uule_pkg::BYTE_W-1:0] sixbit_char(input logic [5:0] value);
      return {2'b00, value} + uule_pkg::SPACE_CHAR;
   endfunction

   task automatic add_char(input logic [uule_pkg::BYTE_W-1:0] c);
      step_chars.push_back('{out_char: c, last_of_run: 1'b0});
   endtask

   // Emit one line from the first count held bytes; pad a short final group
   // with zero bytes.
   task automatic add_line(input int count);
      logic [uule_pkg::BYTE_W-1:0] b0;
      logic [uule_pkg::BYTE_W-1:0] b1;
      logic [uule_pkg::BYTE_W-1:0] b2;
      logic [5:0]                  len6;
      len6 = count[5:0];
      add_char(sixbit_char(len6));
      for (int i = 0; i < count; i += 3) begin
         b0 = held_bytes[i];
         b1 = (i + 1 < count) ? held_bytes[i + 1] : '0;
         b2 = (i + 2 < count) ? held_bytes[i + 2] : '0;
         add_char(sixbit_char(b0[7:2]));
         add_char(sixbit_char({b0[1:0], b1[7:4]}));
         add_char(sixbit_char({b1[3:0], b2[7:6]}));
         add_char(sixbit_char(b2[5:0]));
      end
      add_char(uule_pkg::NEWLINE_CHAR);
   endtask

   // Work out the characters one request produces and advance the model.
   task automatic encode_request(input logic [uule_pkg::BYTE_W-1:0] data_byte,
                                 input logic present, input logic eod);
      int          count;
      uu_char_type tail;
      step_chars.delete();
      count = held_count;
      if (present) begin
         if (count < LINE_LEN) begin
            held_bytes[count] = data_byte;
            count++;
         end
         if (count >= LINE_LEN) begin
            add_line(count);
            full_lines++;
            count = 0;
         end
      end
      if (eod) begin
         if (count > 0) add_line(count);
         count = 0;
         add_char(uule_pkg::SPACE_CHAR);
         add_char(uule_pkg::NEWLINE_CHAR);
      end
      held_count = count;
      // flag the closing character of this request
      if (step_chars.size() > 0) begin
         tail = step_chars.pop_back();
         tail.last_of_run = 1'b1;
         step_chars.push_back(tail);
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   // Hold valid low for a random gap, present the request, then wait for the
   // handshake and update the model in the same time step.
   task automatic apply_request(input logic [uule_pkg::BYTE_W-1:0] data_byte,
                                input logic present, input logic eod);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= data_byte;
      req_bus.byte_present <= present;
      req_bus.end_of_data  <= eod;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
      encode_request(data_byte, present, eod);
   endtask

   task automatic set_phase(input int phase);
      case (phase)
         0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
         1: begin send_idle_pct = 57; rx_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rx_stall_pct = 57; end
         default: begin send_idle_pct = 36; rx_stall_pct = 36; end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   function automatic void report_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endfunction

   task automatic check_char(input logic [uule_pkg::BYTE_W-1:0] c, input logic last);
      uu_char_type want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
         report_failure($sformatf("unexpected character 0x%02h last_of_run %0b", c, last));
      end else begin
         want = pending_chars.pop_front();
         if (want.out_char !== c || want.last_of_run !== last) begin
            report_failure($sformatf(
               "character %0d: expected 0x%02h last_of_run %0b, got 0x%02h last_of_run %0b",
               chars_checked, want.out_char, want.last_of_run, c, last));
         end
      end
   endtask

   // Sample the result channel on every edge, then pick the next ready level.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            check_char(rsp_bus.out_char, rsp_bus.last_of_run);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: give up after a long stretch with no handshake on either side
   // ------------------------------------------------------------------------
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Timeout: no request or character moved for %0d cycles, %0d characters owed",
               WATCHDOG_LIMIT, pending_chars.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int random_items;
      int stream_len;
      bit end_on_byte;
      bit keep_open;
      logic [uule_pkg::BYTE_W-1:0] typed_byte;

      error_count   = 0;
      requests_sent = 0;
      chars_checked = 0;
      streams_sent  = 0;
      full_lines    = 0;
      held_count    = 0;
      random_items  = 0;
      set_phase(0);

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.data_byte    <= '0;
      req_bus.byte_present <= 1'b0;
      req_bus.end_of_data  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; take the typed response where there is one.
      foreach (directed_rows[r]) begin
         apply_request(directed_rows[r].data_byte, directed_rows[r].byte_present,
                       directed_rows[r].end_of_data);
         if (directed_rows[r].typed) begin
            for (int k = 0; k < directed_rows[r].typed_chars.len(); k++) begin
               typed_byte = directed_rows[r].typed_chars[k];
               pending_chars.push_back('{out_char: typed_byte,
                  last_of_run: (k == directed_rows[r].typed_chars.len() - 1)});
            end
         end else begin
            pending_chars = {pending_chars, step_chars};
         end
      end

      // Random streams. Open with a full line whose last byte also ends the
      // stream (the largest response), then an exact line closed by a bare
      // end. Afterwards mix short, line-sized and long streams, with idle
      // requests as noise and the odd stream left open into the next.
      while (random_items < RANDOM_ITEMS) begin
         set_phase(random_items * 4 / RANDOM_ITEMS);
         if (streams_sent < 2) begin
            stream_len  = LINE_LEN;
            end_on_byte = (streams_sent == 0);
            keep_open   = 1'b0;
         end else begin
            case ($urandom_range(9))
               0: stream_len = LINE_LEN;
               1: stream_len = 2 * LINE_LEN;
               2: stream_len = LINE_LEN - 1;
               3: stream_len = LINE_LEN + 1;
               4, 5, 6: stream_len = int'($urandom_range(12, 1));
               7: stream_len = 0;
               default: stream_len = int'($urandom_range(100, 1));
            endcase
            end_on_byte = 1'($urandom_range(1));
            keep_open   = ($urandom_range(9) == 0);
         end
         for (int i = 0; i < stream_len; i++) begin
            if ($urandom_range(9) == 0) begin
               apply_request(8'($urandom_range(255)), 1'b0, 1'b0);
               pending_chars = {pending_chars, step_chars};
            end
            apply_request(8'($urandom_range(255)), 1'b1,
                          !keep_open && end_on_byte && (i == stream_len - 1));
            pending_chars = {pending_chars, step_chars};
            random_items++;
         end
         if (!keep_open && (!end_on_byte || stream_len == 0)) begin
            apply_request(8'($urandom_range(255)), 1'b0, 1'b1);
            pending_chars = {pending_chars, step_chars};
            random_items++;
         end
         streams_sent++;
      end

      // Drop valid, drain what is still owed, then let the pipeline settle.
      req_bus.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d from the directed table) in %0d random streams,",
               requests_sent, N_DIRECTED, streams_sent);
      $display("%0d characters checked, %0d full lines, across four flow-control phases.",
               chars_checked, full_lines);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
